@@ sv/height_field_wave_step_macros.svh @@
// Assertion helpers used by the wave step controller
`ifndef HEIGHT_FIELD_WAVE_STEP_MACROS_SVH
`define HEIGHT_FIELD_WAVE_STEP_MACROS_SVH

`ifndef SYNTHESIS
`define HFWS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define HFWS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define HFWS_ASSERT(lbl, prop, msg)
`define HFWS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ sv/hfws_pkg.sv @@
`default_nettype none
package hfws_pkg;

   localparam int GRID_BITS = 6;
   localparam int GRID_SIDE = 64;
   localparam int CELL_BITS = 2 * GRID_BITS;
   localparam int CELLS     = GRID_SIDE * GRID_SIDE;

   // item opcodes
   localparam logic [1:0] OP_STEP = 2'd0;
   localparam logic [1:0] OP_DROP = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   // register indexes
   localparam logic [1:0] REG_GAIN  = 2'd0;
   localparam logic [1:0] REG_DECAY = 2'd1;
   localparam logic [1:0] REG_LIMIT = 2'd2;
   localparam logic [1:0] REG_DROP  = 2'd3;

   // neighbor selects for the Laplacian reads
   localparam logic [2:0] NB_CENTRE = 3'd0;
   localparam logic [2:0] NB_UP     = 3'd1;
   localparam logic [2:0] NB_DOWN   = 3'd2;
   localparam logic [2:0] NB_LEFT   = 3'd3;
   localparam logic [2:0] NB_RIGHT  = 3'd4;
   localparam logic [2:0] NB_DONE   = 3'd5;

   typedef struct packed {
      logic                 clear;
      logic                 latch_item;
      logic                 use_item;
      logic                 h_rd_en;
      logic [2:0]           nb_sel;
      logic                 v_rd_en;
      logic                 lap_en;
      logic                 lap_first;
      logic                 mul_t;
      logic                 mul_g;
      logic                 add_v;
      logic                 mul_d;
      logic                 v_wr;
      logic                 mul_h;
      logic                 h_wr;
      logic                 drop_wr;
      logic                 load_out;
      logic [CELL_BITS-1:0] cell_addr;
   } hfws_cmd_type;

   // saturate to the signed 32 bit range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sh0000_0000_7FFF_FFFF;
      lo = -64'sh0000_0000_8000_0000;
      if (x > hi) return 32'sh7FFF_FFFF;
      else if (x < lo) return 32'sh8000_0000;
      else return x[31:0];
   endfunction

endpackage
`default_nettype wire

@@ sv/height_field_wave_step.sv @@
`default_nettype none
// Channel   Direction  Beat contents
// req       in         opcode, row, col, time_step
// rsp       out        height, speed (read items only)
// csr       in/out     APB registers gain, decay, limit, drop speed
//
// After reset a clearing pass zeroes both 4096-entry cell memories.
// A step first updates the speed of every cell, with five height reads on the
// single read port of the height memory plus the three-multiply velocity chain,
// then updates the height of every cell. A read waits in place while an earlier
// result is not yet taken.
module height_field_wave_step (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // opcode[1:0] row[7:2] col[13:8] time_step[29:14]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // height[31:0] speed[63:32]
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import hfws_pkg::*;

   hfws_cmd_type       cmd;
   logic [30:0]        gain_ff;
   logic [16:0]        decay_ff;
   logic [30:0]        limit_ff;
   logic signed [31:0] drop_ff;
   logic signed [31:0] height, speed;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= 31'd13107200;
         decay_ff <= 17'd64881;
         limit_ff <= 31'd327680;
         drop_ff  <= -32'sd65536;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_GAIN:  gain_ff  <= csr_pwdata[30:0];
            REG_DECAY: decay_ff <= csr_pwdata[16:0];
            REG_LIMIT: limit_ff <= csr_pwdata[30:0];
            REG_DROP:  drop_ff  <= $signed(csr_pwdata);
            default:   gain_ff  <= gain_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_GAIN:  csr_prdata = {1'b0, gain_ff};
         REG_DECAY: csr_prdata = {15'd0, decay_ff};
         REG_LIMIT: csr_prdata = {1'b0, limit_ff};
         REG_DROP:  csr_prdata = drop_ff;
         default:   csr_prdata = '0;
      endcase
   end

   hfws_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_opcode (req_tdata[1:0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   hfws_dp u_dp (
      .clock         (clock),
      .cmd           (cmd),
      .req_row       (req_tdata[7:2]),
      .req_col       (req_tdata[13:8]),
      .req_time_step (req_tdata[29:14]),
      .wave_gain     (gain_ff),
      .decay_factor  (decay_ff),
      .speed_limit   (limit_ff),
      .drop_speed    (drop_ff),
      .rsp_height    (height),
      .rsp_speed     (speed)
   );

   assign rsp_tdata = {speed, height};
endmodule
`default_nettype wire

@@ sv/hfws_ram.sv @@
`default_nettype none
module hfws_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

@@ sv/hfws_ctrl.sv @@
`default_nettype none
`include "height_field_wave_step_macros.svh"
module hfws_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [1:0]            req_opcode,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output hfws_pkg::hfws_cmd_type     cmd
);
   import hfws_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DROP, S_RRD, S_RWAIT,
      S_VRD, S_VT, S_VG, S_VS, S_VD, S_VW,
      S_HRD, S_HM, S_HW
   } state_type;

   localparam logic [CELL_BITS-1:0] LAST_CELL = CELL_BITS'(CELLS - 1);

   state_type            state_ff, state_in;
   logic [CELL_BITS-1:0] cell_ff, cell_in;
   logic [2:0]           nb_ff, nb_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 accept;
   logic                 out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cell_in       = cell_ff;
      nb_in         = nb_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      cmd           = '0;
      cmd.cell_addr = cell_ff;
      cmd.nb_sel    = NB_CENTRE;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            cell_in   = cell_ff + 1'b1;
            if (cell_ff == LAST_CELL) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               cmd.latch_item = 1'b1;
               cell_in        = '0;
               nb_in          = NB_CENTRE;
               case (req_opcode)
                  OP_STEP: state_in = S_VRD;
                  OP_DROP: state_in = S_DROP;
                  OP_READ: state_in = S_RRD;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_DROP: begin
            cmd.drop_wr = 1'b1;
            state_in    = S_IDLE;
         end
         S_RRD: begin
            cmd.use_item = 1'b1;
            cmd.h_rd_en  = 1'b1;
            cmd.v_rd_en  = 1'b1;
            state_in     = S_RWAIT;
         end
         S_RWAIT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_VRD: begin
            // read five heights back to back, sum each one as its read data returns
            cmd.nb_sel    = nb_ff;
            cmd.h_rd_en   = (nb_ff != NB_DONE);
            cmd.v_rd_en   = (nb_ff == NB_CENTRE);
            cmd.lap_en    = (nb_ff != NB_CENTRE);
            cmd.lap_first = (nb_ff == NB_UP);
            if (nb_ff == NB_DONE) begin
               nb_in    = NB_CENTRE;
               state_in = S_VT;
            end else begin
               nb_in    = nb_ff + 1'b1;
            end
         end
         S_VT: begin
            cmd.mul_t = 1'b1;
            state_in  = S_VG;
         end
         S_VG: begin
            cmd.mul_g = 1'b1;
            state_in  = S_VS;
         end
         S_VS: begin
            cmd.add_v = 1'b1;
            state_in  = S_VD;
         end
         S_VD: begin
            cmd.mul_d = 1'b1;
            state_in  = S_VW;
         end
         S_VW: begin
            cmd.v_wr = 1'b1;
            nb_in    = NB_CENTRE;
            if (cell_ff == LAST_CELL) begin
               cell_in  = '0;
               state_in = S_HRD;
            end else begin
               cell_in  = cell_ff + 1'b1;
               state_in = S_VRD;
            end
         end
         S_HRD: begin
            cmd.h_rd_en = 1'b1;
            cmd.v_rd_en = 1'b1;
            state_in    = S_HM;
         end
         S_HM: begin
            cmd.mul_h = 1'b1;
            state_in  = S_HW;
         end
         S_HW: begin
            cmd.h_wr = 1'b1;
            cell_in  = cell_ff + 1'b1;
            state_in = (cell_ff == LAST_CELL) ? S_IDLE : S_HRD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cell_ff      <= '0;
         nb_ff        <= NB_CENTRE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cell_ff      <= cell_in;
         nb_ff        <= nb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `HFWS_ASSERT(a_nb_range, nb_ff <= NB_DONE, "neighbor phase out of range")
   `HFWS_ASSERT(a_load_free, cmd.load_out |-> (!rsp_valid_ff || rsp_tready), "result overwritten")
   `HFWS_ASSERT(a_load_valid, cmd.load_out |=> rsp_tvalid, "loaded result not shown")
   `HFWS_ASSERT_ALWAYS(a_one_pass, !(cmd.v_wr && cmd.h_wr), "both passes write at once")
endmodule
`default_nettype wire

@@ sv/hfws_dp.sv @@
`default_nettype none
module hfws_dp (
   input  wire logic                   clock,
   input  wire hfws_pkg::hfws_cmd_type cmd,
   input  wire logic [5:0]             req_row,
   input  wire logic [5:0]             req_col,
   input  wire logic [15:0]            req_time_step,
   input  wire logic [30:0]            wave_gain,
   input  wire logic [16:0]            decay_factor,
   input  wire logic [30:0]            speed_limit,
   input  wire logic signed [31:0]     drop_speed,
   output logic signed [31:0]          rsp_height,
   output logic signed [31:0]          rsp_speed
);
   import hfws_pkg::*;

   localparam logic [GRID_BITS-1:0] LAST_IDX = GRID_BITS'(GRID_SIDE - 1);

   logic [CELL_BITS-1:0] item_addr_ff, item_addr_in;
   logic [15:0]          dt_ff;
   logic [GRID_BITS-1:0] row_c, col_c, r, c, nr, nc;
   logic [CELL_BITS-1:0] h_rd_addr, v_rd_addr, v_wr_addr;
   logic signed [31:0]   h_rd, v_rd, h_wr_data, v_wr_data;
   logic                 h_wr_en, v_wr_en;
   logic signed [16:0]   dt_s;
   logic signed [34:0]   lap_ff;
   logic signed [51:0]   prod_t_ff;
   logic signed [63:0]   prod_g_ff;
   logic signed [31:0]   vsum_ff;
   logic signed [49:0]   prod_d_ff;
   logic signed [48:0]   prod_h_ff;
   logic signed [31:0]   t_val, vdec, vnew, lim, hnew;
   logic signed [31:0]   out_h_ff, out_v_ff;

   // clamp the item position to the grid
   assign row_c        = (req_row > LAST_IDX) ? LAST_IDX : req_row;
   assign col_c        = (req_col > LAST_IDX) ? LAST_IDX : req_col;
   assign item_addr_in = {row_c, col_c};
   assign dt_s         = $signed({1'b0, dt_ff});

   always_ff @(posedge clock) begin
      if (cmd.latch_item) begin
         item_addr_ff <= item_addr_in;
         dt_ff        <= req_time_step;
      end
   end

   // neighbor address with edge clamp
   assign r = cmd.cell_addr[CELL_BITS-1:GRID_BITS];
   assign c = cmd.cell_addr[GRID_BITS-1:0];
   always_comb begin
      nr = r;
      nc = c;
      case (cmd.nb_sel)
         NB_UP:    nr = (r == LAST_IDX) ? r : r + 1'b1;
         NB_DOWN:  nr = (r == '0) ? r : r - 1'b1;
         NB_LEFT:  nc = (c == LAST_IDX) ? c : c + 1'b1;
         NB_RIGHT: nc = (c == '0) ? c : c - 1'b1;
         default: begin
            nr = r;
            nc = c;
         end
      endcase
   end

   assign h_rd_addr = cmd.use_item ? item_addr_ff : {nr, nc};
   assign v_rd_addr = cmd.use_item ? item_addr_ff : cmd.cell_addr;
   assign v_wr_addr = cmd.drop_wr ? item_addr_ff : cmd.cell_addr;
   assign h_wr_en   = cmd.clear || cmd.h_wr;
   assign v_wr_en   = cmd.clear || cmd.v_wr || cmd.drop_wr;
   assign h_wr_data = cmd.clear ? '0 : hnew;
   assign v_wr_data = cmd.clear ? '0 : (cmd.drop_wr ? drop_speed : vnew);

   hfws_ram #(.WIDTH(32), .DEPTH(CELLS)) u_heights (
      .clock   (clock),
      .wr_en   (h_wr_en),
      .wr_addr (cmd.cell_addr),
      .wr_data (h_wr_data),
      .rd_en   (cmd.h_rd_en),
      .rd_addr (h_rd_addr),
      .rd_data (h_rd)
   );

   hfws_ram #(.WIDTH(32), .DEPTH(CELLS)) u_speeds (
      .clock   (clock),
      .wr_en   (v_wr_en),
      .wr_addr (v_wr_addr),
      .wr_data (v_wr_data),
      .rd_en   (cmd.v_rd_en),
      .rd_addr (v_rd_addr),
      .rd_data (v_rd)
   );

   // velocity and height pass arithmetic, one register per step
   assign t_val = sat32(64'(prod_t_ff >>> 16));
   assign lim   = $signed({1'b0, speed_limit});
   assign vdec  = sat32(64'(prod_d_ff >>> 16));
   assign vnew  = (vdec > lim) ? lim : ((vdec < -lim) ? -lim : vdec);
   assign hnew  = sat32(64'(h_rd) + 64'(prod_h_ff >>> 16));

   always_ff @(posedge clock) begin
      if (cmd.lap_en) begin
         if (cmd.lap_first) lap_ff <= -(35'(h_rd) <<< 2);
         else lap_ff <= lap_ff + 35'(h_rd);
      end
      if (cmd.mul_t) prod_t_ff <= lap_ff * dt_s;
      if (cmd.mul_g) prod_g_ff <= t_val * $signed({1'b0, wave_gain});
      if (cmd.add_v) vsum_ff <= sat32(64'(v_rd) + (prod_g_ff >>> 16));
      if (cmd.mul_d) prod_d_ff <= vsum_ff * $signed({1'b0, decay_factor});
      if (cmd.mul_h) prod_h_ff <= v_rd * dt_s;
      if (cmd.load_out) begin
         out_h_ff <= h_rd;
         out_v_ff <= v_rd;
      end
   end

   assign rsp_height = out_h_ff;
   assign rsp_speed  = out_v_ff;
endmodule
`default_nettype wire

@@ sim/hfws_checker.sv @@
module hfws_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,   // opcode[1:0] row[7:2] col[13:8] time_step[29:14]
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [63:0] rsp_tdata,   // height[31:0] speed[63:32]
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output int               fail_count,
   output int               reads_pending
);
   import hfws_pkg::*;

   typedef struct {
      logic signed [31:0] height;
      logic signed [31:0] speed;
   } cell_read_type;

   // shadow of the grid and the registers
   logic signed [31:0] grid_height [CELLS];
   logic signed [31:0] grid_speed  [CELLS];
   logic [30:0]        gain_q;
   logic [16:0]        decay_q;
   logic [30:0]        limit_q;
   logic signed [31:0] drop_q;
   cell_read_type      cell_reads [$];

   assign reads_pending = cell_reads.size();

   function automatic longint clip32(input longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic int edge_idx(input int i);
      if (i < 0) return 0;
      if (i > GRID_SIDE - 1) return GRID_SIDE - 1;
      return i;
   endfunction

   function automatic longint height_at(input int r, input int c);
      return longint'(grid_height[edge_idx(r) * GRID_SIDE + edge_idx(c)]);
   endfunction

   // one time step: all velocities from old heights, then all heights
   task automatic advance_grid(input longint dt);
      longint lap, t, a, v, lim;
      int     idx;
      lim = longint'(limit_q);
      for (int r = 0; r < GRID_SIDE; r++) begin
         for (int c = 0; c < GRID_SIDE; c++) begin
            idx = r * GRID_SIDE + c;
            lap = height_at(r + 1, c) + height_at(r - 1, c) + height_at(r, c + 1)
                + height_at(r, c - 1) - 4 * longint'(grid_height[idx]);
            t = clip32((lap * dt) >>> 16);
            a = (t * longint'(gain_q)) >>> 16;
            v = clip32(longint'(grid_speed[idx]) + a);
            v = clip32((v * longint'(decay_q)) >>> 16);
            if (v > lim) v = lim;
            else if (v < -lim) v = -lim;
            grid_speed[idx] = v[31:0];
         end
      end
      for (int i = 0; i < CELLS; i++)
         grid_height[i] = 32'(clip32(longint'(grid_height[i])
                                     + ((longint'(grid_speed[i]) * dt) >>> 16)));
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      logic [1:0]    op;
      int            idx;
      cell_read_type exp_read;
      if (reset) begin
         gain_q  = 31'd13107200;
         decay_q = 17'd64881;
         limit_q = 31'd327680;
         drop_q  = -32'sd65536;
         for (int i = 0; i < CELLS; i++) begin
            grid_height[i] = '0;
            grid_speed[i]  = '0;
         end
         cell_reads.delete();
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite) begin
            case (csr_paddr[3:2])
               REG_GAIN:  gain_q  = csr_pwdata[30:0];
               REG_DECAY: decay_q = csr_pwdata[16:0];
               REG_LIMIT: limit_q = csr_pwdata[30:0];
               REG_DROP:  drop_q  = csr_pwdata;
               default: ;
            endcase
         end
         // result beat against oldest read
         if (rsp_tvalid && rsp_tready) begin
            if (cell_reads.size() == 0) begin
               report("unexpected beat", rsp_tdata[31:0], '0);
            end else begin
               exp_read = cell_reads.pop_front();
               if (rsp_tdata[31:0] !== exp_read.height)
                  report("height", rsp_tdata[31:0], exp_read.height);
               if (rsp_tdata[63:32] !== exp_read.speed)
                  report("speed", rsp_tdata[63:32], exp_read.speed);
            end
         end
         // accepted item
         if (req_tvalid && req_tready) begin
            op  = req_tdata[1:0];
            idx = edge_idx(int'(req_tdata[7:2])) * GRID_SIDE
                + edge_idx(int'(req_tdata[13:8]));
            case (op)
               OP_STEP: advance_grid(longint'(req_tdata[29:14]));
               OP_DROP: grid_speed[idx] = drop_q;
               OP_READ: begin
                  exp_read.height = grid_height[idx];
                  exp_read.speed  = grid_speed[idx];
                  cell_reads = {cell_reads, exp_read};
               end
               default: ;
            endcase
         end
      end
   end

endmodule

@@ sim/tb.sv @@
module tb;
   import hfws_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 4000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // opcode[1:0] row[7:2] col[13:8] time_step[29:14]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // height[31:0] speed[63:32]
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          reads_pending;
   int          burst_left = 0;
   int          cycle_count = 0;
   int          stall_mode = 0;

   height_field_wave_step DUT (.*);
   hfws_checker u_checker (.*);

   initial forever #4 clock = ~clock;

   // timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // receiver stalls under a randomly redrawn mode
   always @(posedge clock) begin
      if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 1) == 0);
         2: rsp_tready <= ($urandom_range(0, 7) == 0);
         default: rsp_tready <= (cycle_count % 16) < 10;
      endcase
   end

   task automatic send_item(input logic [1:0] op, input logic [5:0] r, input logic [5:0] c,
                            input logic [15:0] dt);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 4);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, dt, c, r, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (reads_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] reg_idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {reg_idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // positions biased towards the edges and the centre so reads see live cells
   function automatic logic [5:0] pick_pos();
      case ($urandom_range(0, 3))
         0: return 6'($urandom_range(0, 3));
         1: return 6'($urandom_range(60, 63));
         2: return 6'($urandom_range(0, 63));
         default: return 6'($urandom_range(28, 35));
      endcase
   endfunction

   initial begin
      logic [1:0]  op;
      logic [31:0] cfg [4];
      int          steps_done;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: corners, center, all opcodes, ignored opcode
      send_item(OP_DROP, 6'd0, 6'd0, 16'hFFFF);
      send_item(OP_DROP, 6'd63, 6'd63, 16'h0000);
      send_item(OP_DROP, 6'd63, 6'd0, 16'h1234);
      send_item(OP_DROP, 6'd30, 6'd31, 16'h0);
      send_item(OP_READ, 6'd0, 6'd0, 16'h0);
      send_item(OP_UNUSED, 6'd0, 6'd1, 16'hFFFF);
      send_item(OP_READ, 6'd0, 6'd1, 16'h0);
      send_item(OP_STEP, 6'd63, 6'd63, 16'hFFFF);
      send_item(OP_READ, 6'd0, 6'd0, 16'h0);
      send_item(OP_READ, 6'd0, 6'd1, 16'h0);
      send_item(OP_READ, 6'd63, 6'd63, 16'h0);
      send_item(OP_READ, 6'd30, 6'd31, 16'h0);
      send_item(OP_STEP, 6'd0, 6'd0, 16'h0000);
      send_item(OP_READ, 6'd63, 6'd0, 16'h0);
      send_item(OP_READ, 6'd1, 6'd0, 16'h0);
      drain();

      // phases over register settings, extremes included
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: cfg = '{32'hFFFF_FFFF, 32'h0001_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF};
            1: cfg = '{32'h0, 32'h0, 32'h0, 32'h8000_0000};
            2: cfg = '{$urandom_range(0, 32'h0200_0000), 32'h0001_0000,
                       $urandom(), $urandom()};
            3: cfg = '{$urandom(), $urandom_range(0, 17'h1FFFF),
                       $urandom_range(0, 32'h0010_0000), $urandom()};
            default: cfg = '{32'h00C8_0000, 32'h0000_FD71, 32'h0005_0000, 32'hFFFF_0000};
         endcase
         csr_write(REG_GAIN, cfg[0]);
         csr_write(REG_DECAY, cfg[1]);
         csr_write(REG_LIMIT, cfg[2]);
         csr_write(REG_DROP, cfg[3]);
         steps_done = 0;
         for (int n = 0; n < 26; n++) begin
            case ($urandom_range(0, 19))
               0, 1:    op = (steps_done < 2) ? OP_STEP : OP_DROP;
               2:       op = OP_UNUSED;
               3, 4, 5, 6, 7, 8: op = OP_DROP;
               default: op = OP_READ;
            endcase
            if (op == OP_STEP) steps_done++;
            send_item(op, pick_pos(), pick_pos(), 16'($urandom()));
         end
         // last beat of a phase is a read, so the block is idle once it arrives
         send_item(OP_READ, pick_pos(), pick_pos(), 16'($urandom()));
         drain();
      end

      repeat (16) @(posedge clock);
      if (fail_count == 0 && reads_pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
